### rtl/core/ftrb_pkg.sv
// ----------------------------------------------------------------------------
// Fused tile region back-projection package
// Shared constants, payload structs, table entry layout and sequencer states.
// ----------------------------------------------------------------------------
package ftrb_pkg;

  localparam int MAX_LAYERS     = 16;
  localparam int LAYER_BITS     = $clog2(MAX_LAYERS);
  localparam int MAX_GRID       = 8;
  localparam int GRID_BITS      = 4;
  localparam int CELL_BITS      = 2 * GRID_BITS;
  localparam int DIM_BITS       = 12;
  localparam int EXT_BITS       = 13;
  localparam int TILE_BITS      = 6;
  localparam int PARAM_BITS     = 4;
  localparam int COUNT_BITS     = 5;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 5;
  localparam int DIVIDEND_BITS  = EXT_BITS + 1;
  localparam int DIVISOR_BITS   = GRID_BITS;
  localparam int DIV_CNT_BITS   = $clog2(DIVIDEND_BITS);
  localparam int MAC_BITS       = 20;
  localparam int STEP_BITS      = 2;

  localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TILE = 1'b1;

  localparam logic LAYER_CONV = 1'b0;
  localparam logic LAYER_POOL = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_TILE_COLS   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TILE_ROWS   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LAYER_COUNT = 2'd2;

  typedef struct packed {
    logic                  kind;
    logic [TILE_BITS-1:0]  tile_index;
    logic [LAYER_BITS-1:0] layer_index;
    logic                  layer_type;
    logic [PARAM_BITS-1:0] stride;
    logic [PARAM_BITS-1:0] filter_size;
    logic [EXT_BITS-1:0]   in_width;
    logic [EXT_BITS-1:0]   in_height;
    logic [EXT_BITS-1:0]   in_channels;
    logic [EXT_BITS-1:0]   out_width;
    logic [EXT_BITS-1:0]   out_height;
    logic [EXT_BITS-1:0]   out_channels;
  } ftrb_item_t;

  typedef struct packed {
    logic [LAYER_BITS-1:0] layer_number;
    logic [DIM_BITS-1:0]   out_x_lo;
    logic [DIM_BITS-1:0]   out_x_hi;
    logic [DIM_BITS-1:0]   out_y_lo;
    logic [DIM_BITS-1:0]   out_y_hi;
    logic [DIM_BITS-1:0]   in_x_lo;
    logic [DIM_BITS-1:0]   in_x_hi;
    logic [DIM_BITS-1:0]   in_y_lo;
    logic [DIM_BITS-1:0]   in_y_hi;
    logic [EXT_BITS-1:0]   region_in_channels;
    logic [EXT_BITS-1:0]   region_out_channels;
    logic                  last;
  } ftrb_result_t;

  typedef struct packed {
    logic                  layer_type;
    logic [PARAM_BITS-1:0] stride;
    logic [PARAM_BITS-1:0] filter_size;
    logic [EXT_BITS-1:0]   in_channels;
    logic [EXT_BITS-1:0]   out_channels;
    logic [EXT_BITS-1:0]   in_width;
    logic [EXT_BITS-1:0]   in_height;
    logic [EXT_BITS-1:0]   out_width;
    logic [EXT_BITS-1:0]   out_height;
  } ftrb_entry_t;

  typedef struct packed {
    logic                     start;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [DIVISOR_BITS-1:0]  divisor;
  } ftrb_div_req_t;

  typedef struct packed {
    logic                     done;
    logic [DIVIDEND_BITS-1:0] quotient;
    logic [DIVISOR_BITS-1:0]  remainder;
  } ftrb_div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_LATCH,
    S_DIV_TILE,
    S_DIV_W,
    S_DIV_H,
    S_GRID,
    S_LAYER,
    S_OUT
  } ftrb_state_t;

endpackage

### rtl/core/ftrb_item_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying table loads and tile requests.
// ----------------------------------------------------------------------------
interface ftrb_item_if;
  logic                valid;
  logic                ready;
  ftrb_pkg::ftrb_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/ftrb_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one region pair per fused layer.
// ----------------------------------------------------------------------------
interface ftrb_result_if;
  logic                  valid;
  logic                  ready;
  ftrb_pkg::ftrb_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/ftrb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ftrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ftrb_divider.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module ftrb_divider (
  input  logic                    clk,
  input  logic                    rst,
  input  ftrb_pkg::ftrb_div_req_t req,
  output ftrb_pkg::ftrb_div_rsp_t rsp
);

  logic                                     busy;
  logic                                     done;
  logic [ftrb_pkg::DIV_CNT_BITS-1:0]        cnt;
  logic [ftrb_pkg::DIVIDEND_BITS-1:0]       quo;
  logic [ftrb_pkg::DIVISOR_BITS-1:0]        rem;
  logic [ftrb_pkg::DIVISOR_BITS-1:0]        divisor;
  logic [ftrb_pkg::DIVISOR_BITS:0]          trial;
  logic                                     fits;

  assign trial = {rem, quo[ftrb_pkg::DIVIDEND_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= ftrb_pkg::DIV_CNT_BITS'(ftrb_pkg::DIVIDEND_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[ftrb_pkg::DIVIDEND_BITS-2:0], fits};
      rem <= fits ? ftrb_pkg::DIVISOR_BITS'(trial - {1'b0, divisor})
                  : trial[ftrb_pkg::DIVISOR_BITS-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

### rtl/core/fused_tile_region_backprojection.sv
// ----------------------------------------------------------------------------
// Fused tile region back-projection
// Loads a table of fused CNN layers and, for each tile request, walks from the
// last layer to the first emitting each layer's output and input regions.
// ----------------------------------------------------------------------------
// A table load leaves the block ready for the next item. A tile request on a
// grid larger than 1x1 uses one shared restoring divider to find the tile
// column and row, then the strip width and the strip height. One shared
// multiply-add and clamp unit then works out the four bounds of a region,
// first for the output grid region of the last layer and then for the input
// region of each layer, besides a table read and one result transfer per
// layer. On a 1x1 grid each layer's regions are the full extents. An
// out-of-range tile index is taken and gives no result. The block accepts
// no new item while a tile request is in progress.
// ----------------------------------------------------------------------------
module fused_tile_region_backprojection (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ftrb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ftrb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  ftrb_item_if.sink                           item,
  ftrb_result_if.source                       result
);

  function automatic logic [ftrb_pkg::DIM_BITS-1:0] sat(
    input logic signed [ftrb_pkg::MAC_BITS-1:0] v
  );
    logic [ftrb_pkg::DIM_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(ftrb_pkg::MAC_BITS'(ftrb_pkg::DIM_MAX))) begin
      r = ftrb_pkg::DIM_MAX;
    end else begin
      r = v[ftrb_pkg::DIM_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic [ftrb_pkg::DIM_BITS-1:0] sat_m1(
    input logic [ftrb_pkg::EXT_BITS-1:0] x
  );
    return sat(ftrb_pkg::MAC_BITS'(x) - ftrb_pkg::MAC_BITS'(1));
  endfunction

  logic [ftrb_pkg::GRID_BITS-1:0]  tile_cols;
  logic [ftrb_pkg::GRID_BITS-1:0]  tile_rows;
  logic [ftrb_pkg::COUNT_BITS-1:0] layer_count;

  logic [ftrb_pkg::GRID_BITS-1:0]  cols;
  logic [ftrb_pkg::GRID_BITS-1:0]  rows;
  logic [ftrb_pkg::LAYER_BITS-1:0] last_layer;
  logic [ftrb_pkg::CELL_BITS-1:0]  cells;
  logic                            single;

  ftrb_pkg::ftrb_state_t state;
  ftrb_pkg::ftrb_state_t state_next;

  logic [ftrb_pkg::LAYER_BITS-1:0]    q;
  logic [ftrb_pkg::STEP_BITS-1:0]     step;
  logic [ftrb_pkg::TILE_BITS-1:0]     tile;
  logic [ftrb_pkg::GRID_BITS-1:0]     cc;
  logic [ftrb_pkg::GRID_BITS-1:0]     rr;
  logic [ftrb_pkg::DIVIDEND_BITS-1:0] sw;
  logic [ftrb_pkg::DIVIDEND_BITS-1:0] sh;
  ftrb_pkg::ftrb_entry_t              entry;
  ftrb_pkg::ftrb_entry_t              wentry;
  ftrb_pkg::ftrb_entry_t              rentry;
  logic [ftrb_pkg::EXT_BITS-1:0]      oc;
  logic [ftrb_pkg::DIM_BITS-1:0]      o_xl, o_xh, o_yl, o_yh;
  logic [ftrb_pkg::DIM_BITS-1:0]      i_xl, i_xh, i_yl, i_yh;

  ftrb_pkg::ftrb_div_req_t div_req;
  ftrb_pkg::ftrb_div_rsp_t div_rsp;

  logic                                 load_we;
  logic [ftrb_pkg::DIVIDEND_BITS-1:0]   mac_a;
  logic [ftrb_pkg::PARAM_BITS-1:0]      mac_b;
  logic [ftrb_pkg::MAC_BITS-1:0]        mac_c;
  logic [ftrb_pkg::MAC_BITS-1:0]        half;
  logic signed [ftrb_pkg::MAC_BITS-1:0] mac_v;
  logic signed [ftrb_pkg::MAC_BITS-1:0] lim_m1;
  logic signed [ftrb_pkg::MAC_BITS-1:0] hi_v;
  logic [ftrb_pkg::GRID_BITS-1:0]       pos;
  logic [ftrb_pkg::GRID_BITS-1:0]       span;
  logic [ftrb_pkg::EXT_BITS-1:0]        ext;
  logic [ftrb_pkg::EXT_BITS-1:0]        lim;
  logic                                 clamp_hi;
  logic [ftrb_pkg::DIM_BITS-1:0]        unit_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_cols   <= ftrb_pkg::GRID_BITS'(1);
      tile_rows   <= ftrb_pkg::GRID_BITS'(1);
      layer_count <= ftrb_pkg::COUNT_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ftrb_pkg::CFG_TILE_COLS: begin
          tile_cols <= cfg_data[ftrb_pkg::GRID_BITS-1:0];
        end
        ftrb_pkg::CFG_TILE_ROWS: begin
          tile_rows <= cfg_data[ftrb_pkg::GRID_BITS-1:0];
        end
        ftrb_pkg::CFG_LAYER_COUNT: begin
          layer_count <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (tile_cols == '0) begin
      cols = ftrb_pkg::GRID_BITS'(1);
    end else if (tile_cols > ftrb_pkg::GRID_BITS'(ftrb_pkg::MAX_GRID)) begin
      cols = ftrb_pkg::GRID_BITS'(ftrb_pkg::MAX_GRID);
    end else begin
      cols = tile_cols;
    end
    if (tile_rows == '0) begin
      rows = ftrb_pkg::GRID_BITS'(1);
    end else if (tile_rows > ftrb_pkg::GRID_BITS'(ftrb_pkg::MAX_GRID)) begin
      rows = ftrb_pkg::GRID_BITS'(ftrb_pkg::MAX_GRID);
    end else begin
      rows = tile_rows;
    end
    if (layer_count == '0) begin
      last_layer = '0;
    end else if (layer_count > ftrb_pkg::COUNT_BITS'(ftrb_pkg::MAX_LAYERS)) begin
      last_layer = ftrb_pkg::LAYER_BITS'(ftrb_pkg::MAX_LAYERS - 1);
    end else begin
      last_layer = ftrb_pkg::LAYER_BITS'(layer_count - ftrb_pkg::COUNT_BITS'(1));
    end
  end

  assign cells  = ftrb_pkg::CELL_BITS'(cols * rows);
  assign single = cells == ftrb_pkg::CELL_BITS'(1);

  assign load_we = item.valid && item.ready && item.data.kind == ftrb_pkg::KIND_LOAD;

  always_comb begin
    wentry.layer_type   = item.data.layer_type;
    wentry.stride       = item.data.stride;
    wentry.filter_size  = item.data.filter_size;
    wentry.in_channels  = item.data.in_channels;
    wentry.out_channels = item.data.out_channels;
    wentry.in_width     = item.data.in_width;
    wentry.in_height    = item.data.in_height;
    wentry.out_width    = item.data.out_width;
    wentry.out_height   = item.data.out_height;
  end

  ftrb_ram #(
    .WIDTH ($bits(ftrb_pkg::ftrb_entry_t)),
    .DEPTH (ftrb_pkg::MAX_LAYERS)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (item.data.layer_index),
    .wdata (wentry),
    .raddr (q),
    .rdata (rentry)
  );

  ftrb_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftrb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    item.ready       = 1'b0;
    result.valid     = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = ftrb_pkg::DIVIDEND_BITS'(tile);
    div_req.divisor  = cols;
    unique case (state)
      ftrb_pkg::S_IDLE: begin
        item.ready = 1'b1;
        if (item.valid && item.data.kind == ftrb_pkg::KIND_TILE &&
            ftrb_pkg::CELL_BITS'(item.data.tile_index) < cells) begin
          state_next = ftrb_pkg::S_FETCH;
        end
      end
      ftrb_pkg::S_FETCH: begin
        state_next = ftrb_pkg::S_LATCH;
      end
      ftrb_pkg::S_LATCH: begin
        if (single) begin
          state_next = ftrb_pkg::S_OUT;
        end else if (q == last_layer) begin
          div_req.start = 1'b1;
          state_next    = ftrb_pkg::S_DIV_TILE;
        end else begin
          state_next = ftrb_pkg::S_LAYER;
        end
      end
      ftrb_pkg::S_DIV_TILE: begin
        div_req.dividend = ftrb_pkg::DIVIDEND_BITS'(entry.out_width) +
                           ftrb_pkg::DIVIDEND_BITS'(cols) - ftrb_pkg::DIVIDEND_BITS'(1);
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_next    = ftrb_pkg::S_DIV_W;
        end
      end
      ftrb_pkg::S_DIV_W: begin
        div_req.dividend = ftrb_pkg::DIVIDEND_BITS'(entry.out_height) +
                           ftrb_pkg::DIVIDEND_BITS'(rows) - ftrb_pkg::DIVIDEND_BITS'(1);
        div_req.divisor  = rows;
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_next    = ftrb_pkg::S_DIV_H;
        end
      end
      ftrb_pkg::S_DIV_H: begin
        if (div_rsp.done) begin
          state_next = ftrb_pkg::S_GRID;
        end
      end
      ftrb_pkg::S_GRID: begin
        if (step == '1) begin
          state_next = ftrb_pkg::S_LAYER;
        end
      end
      ftrb_pkg::S_LAYER: begin
        if (step == '1) begin
          state_next = ftrb_pkg::S_OUT;
        end
      end
      ftrb_pkg::S_OUT: begin
        result.valid = 1'b1;
        if (result.ready) begin
          state_next = (q == '0) ? ftrb_pkg::S_IDLE : ftrb_pkg::S_FETCH;
        end
      end
      default: begin
        state_next = ftrb_pkg::S_IDLE;
      end
    endcase
  end

  // Shared multiply-add and clamp unit. Step bit 1 selects the y axis and
  // step bit 0 the high bound.
  always_comb begin
    half     = ftrb_pkg::MAC_BITS'(entry.filter_size[ftrb_pkg::PARAM_BITS-1:1]);
    pos      = step[1] ? rr : cc;
    span     = step[1] ? rows : cols;
    ext      = step[1] ? entry.out_height : entry.out_width;
    lim      = step[1] ? entry.in_height : entry.in_width;
    clamp_hi = !(entry.layer_type == ftrb_pkg::LAYER_POOL &&
                 entry.stride == entry.filter_size);
    if (state == ftrb_pkg::S_GRID) begin
      mac_a = step[1] ? sh : sw;
      mac_b = step[0] ? pos + ftrb_pkg::GRID_BITS'(1) : pos;
      mac_c = step[0] ? '1 : '0;
    end else begin
      unique case (step)
        2'd0: mac_a = ftrb_pkg::DIVIDEND_BITS'(o_xl);
        2'd1: mac_a = ftrb_pkg::DIVIDEND_BITS'(o_xh);
        2'd2: mac_a = ftrb_pkg::DIVIDEND_BITS'(o_yl);
        default: mac_a = ftrb_pkg::DIVIDEND_BITS'(o_yh);
      endcase
      mac_b = entry.stride;
      if (entry.layer_type == ftrb_pkg::LAYER_CONV) begin
        mac_c = step[0] ? half : -half;
      end else begin
        mac_c = step[0] ? ftrb_pkg::MAC_BITS'(entry.filter_size) - ftrb_pkg::MAC_BITS'(1)
                        : '0;
      end
    end
    mac_v  = ftrb_pkg::MAC_BITS'(mac_a * mac_b) + mac_c;
    lim_m1 = ftrb_pkg::MAC_BITS'(lim) - ftrb_pkg::MAC_BITS'(1);
    hi_v   = (clamp_hi && lim_m1 < mac_v) ? lim_m1 : mac_v;
    if (state == ftrb_pkg::S_GRID) begin
      if (step[0] && pos == span - ftrb_pkg::GRID_BITS'(1)) begin
        unit_out = sat_m1(ext);
      end else begin
        unit_out = sat(mac_v);
      end
    end else begin
      unit_out = sat(step[0] ? hi_v : mac_v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q    <= '0;
      step <= '0;
      i_xl <= '0;
      i_xh <= '0;
      i_yl <= '0;
      i_yh <= '0;
    end else begin
      unique case (state)
        ftrb_pkg::S_IDLE: begin
          step <= '0;
          if (item.valid && item.data.kind == ftrb_pkg::KIND_TILE) begin
            q    <= last_layer;
            tile <= item.data.tile_index;
          end
        end
        ftrb_pkg::S_LATCH: begin
          entry <= rentry;
          if (single) begin
            o_xl <= '0;
            o_xh <= sat_m1(rentry.out_width);
            o_yl <= '0;
            o_yh <= sat_m1(rentry.out_height);
            i_xl <= '0;
            i_xh <= sat_m1(rentry.in_width);
            i_yl <= '0;
            i_yh <= sat_m1(rentry.in_height);
            oc   <= rentry.out_channels;
          end else if (q == last_layer) begin
            oc <= rentry.out_channels;
          end
        end
        ftrb_pkg::S_DIV_TILE: begin
          if (div_rsp.done) begin
            cc <= div_rsp.remainder;
            rr <= ftrb_pkg::GRID_BITS'(div_rsp.quotient);
          end
        end
        ftrb_pkg::S_DIV_W: begin
          if (div_rsp.done) begin
            sw <= div_rsp.quotient;
          end
        end
        ftrb_pkg::S_DIV_H: begin
          if (div_rsp.done) begin
            sh <= div_rsp.quotient;
          end
        end
        ftrb_pkg::S_GRID: begin
          step <= step + 1'b1;
          unique case (step)
            2'd0: o_xl <= unit_out;
            2'd1: o_xh <= unit_out;
            2'd2: o_yl <= unit_out;
            default: o_yh <= unit_out;
          endcase
        end
        ftrb_pkg::S_LAYER: begin
          step <= step + 1'b1;
          unique case (step)
            2'd0: i_xl <= unit_out;
            2'd1: i_xh <= unit_out;
            2'd2: i_yl <= unit_out;
            default: i_yh <= unit_out;
          endcase
        end
        ftrb_pkg::S_OUT: begin
          if (result.ready && q != '0) begin
            q    <= q - 1'b1;
            o_xl <= i_xl;
            o_xh <= i_xh;
            o_yl <= i_yl;
            o_yh <= i_yh;
            oc   <= entry.in_channels;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.data.layer_number        = q;
    result.data.out_x_lo            = o_xl;
    result.data.out_x_hi            = o_xh;
    result.data.out_y_lo            = o_yl;
    result.data.out_y_hi            = o_yh;
    result.data.in_x_lo             = i_xl;
    result.data.in_x_hi             = i_xh;
    result.data.in_y_lo             = i_yl;
    result.data.in_y_hi             = i_yh;
    result.data.region_in_channels  = entry.in_channels;
    result.data.region_out_channels = oc;
    result.data.last                = q == '0;
  end

endmodule

### rtl/core/ftrb_checker.sv
// ----------------------------------------------------------------------------
// Fused tile region back-projection checker
// Port-level assertions on sequencing of loads, requests and results.
// ----------------------------------------------------------------------------
module ftrb_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               item_valid,
  input logic                               item_ready,
  input logic                               item_kind,
  input logic                               result_valid,
  input logic                               result_ready,
  input logic                               result_last,
  input logic [ftrb_pkg::LAYER_BITS-1:0]    result_layer_number,
  input ftrb_pkg::ftrb_result_t             result_data
);

  a_load_keeps_ready: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_kind == ftrb_pkg::KIND_LOAD |=> item_ready)
    else $error("table load did not leave the input ready");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && result_last |=> !result_valid && item_ready)
    else $error("run did not end after the final result transfer");

  a_more_stays_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result_last |=> !item_ready)
    else $error("input ready before the run finished");

  a_last_is_layer_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_last == (result_layer_number == '0)))
    else $error("last flag does not match layer zero");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("stalled result changed");

endmodule

bind fused_tile_region_backprojection ftrb_checker u_checker (
  .clk                 (clk),
  .rst                 (rst),
  .item_valid          (item.valid),
  .item_ready          (item.ready),
  .item_kind           (item.data.kind),
  .result_valid        (result.valid),
  .result_ready        (result.ready),
  .result_last         (result.data.last),
  .result_layer_number (result.data.layer_number),
  .result_data         (result.data)
);
